// ===== hw/rtl/str_pkg.sv =====
`default_nettype none

package str_pkg;

  // Field widths of the request and response channels.
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned STAT_W      = 16;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CNT_OUT_W   = 9;

  // Depth of the request queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_END   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ
  } eng_state_e;

  // A decoded request as it travels from the front to the back end.
  typedef struct packed {
    cmd_e                      cmd;
    logic [ID_W-1:0]           end_id;
    logic signed [STAT_W-1:0]  status_in;
    logic [TAG_W-1:0]          new_tag;
    logic [TIME_W-1:0]         now_ms;
    logic [IDX_W-1:0]          read_index;
  } op_t;

  // One span record in the ring.
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [TAG_W-1:0]          tag;
    logic [TIME_W-1:0]         start;
    logic [TIME_W-1:0]         stop;
    logic signed [STAT_W-1:0]  status;
    logic                      open;
  } rec_t;

  // One response as held in the output register.
  typedef struct packed {
    logic [ID_W-1:0]           span_id;
    logic                      matched;
    logic [CNT_OUT_W-1:0]      entry_count;
    logic                      entry_valid;
    logic [TAG_W-1:0]          entry_tag;
    logic [TIME_W-1:0]         start_time;
    logic [TIME_W-1:0]         end_time;
    logic [TIME_W-1:0]         duration;
    logic signed [STAT_W-1:0]  status_out;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/str_chan_if.sv =====
`default_nettype none

// Request channel: one command with its operands.
interface str_req_if;
  import str_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [ID_W-1:0]           end_id;
  logic signed [STAT_W-1:0]  status_in;
  logic [TAG_W-1:0]          new_tag;
  logic [TIME_W-1:0]         now_ms;
  logic [IDX_W-1:0]          read_index;

  modport source (
    output valid, cmd, end_id, status_in, new_tag, now_ms, read_index,
    input  ready
  );

  modport sink (
    input  valid, cmd, end_id, status_in, new_tag, now_ms, read_index,
    output ready
  );
endinterface

// Response channel: one result per command.
interface str_rsp_if;
  import str_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ID_W-1:0]           span_id;
  logic                      matched;
  logic [CNT_OUT_W-1:0]      entry_count;
  logic                      entry_valid;
  logic [TAG_W-1:0]          entry_tag;
  logic [TIME_W-1:0]         start_time;
  logic [TIME_W-1:0]         end_time;
  logic [TIME_W-1:0]         duration;
  logic signed [STAT_W-1:0]  status_out;

  modport source (
    output valid, span_id, matched, entry_count, entry_valid, entry_tag,
           start_time, end_time, duration, status_out,
    input  ready
  );

  modport sink (
    input  valid, span_id, matched, entry_count, entry_valid, entry_tag,
           start_time, end_time, duration, status_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/span_trace_ring.sv =====
// Span trace ring: a circular log of DEPTH span records.
// Requests arrive on req_i (cmd, end_id, status_in, new_tag, now_ms,
// read_index) and each produces exactly one response on rsp_o, in order.
// A request is taken when valid and ready are both high; ready drops only
// when the two-entry request queue is full.
// With nothing queued, begin and clear load the response register straight
// from the queue head; read first fetches its slot into the memory read
// register, and end first walks at most DEPTH slots, newest first.
// Begin and clear are taken one per cycle while the output register is free.
// Read and end hold off the next request until their response is loaded;
// the search reads the record memory one slot per cycle via its single port.
// Reset empties the ring, sets the write pointer to slot zero and the next
// span id to 1; no memory clearing is needed, since only filled slots are
// ever read. Clear empties the ring but keeps the id counter.
// When the receiver stalls, the response holds in the output register and
// the queue keeps taking requests until it is full.
`default_nettype none

module span_trace_ring #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  str_req_if.sink   req_i,
  str_rsp_if.source rsp_o
);
  import str_pkg::*;

  op_t  op;
  logic op_valid;
  logic op_pop;

  // Front end: accept, decode and queue requests.
  str_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  // Back end: ring memory, search and read engine, output register.
  str_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/str_front.sv =====
`default_nettype none

module str_front (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  str_req_if.sink     req_i,
  output logic        op_valid_o,
  output str_pkg::op_t op_o,
  input  wire logic   op_pop_i
);
  import str_pkg::*;

  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QUEUE_DEPTH);

  op_t               q_mem [QUEUE_DEPTH];
  op_t               in_op;
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  // Decode the incoming request into a command and its operands.
  always_comb begin
    in_op            = '0;
    in_op.cmd        = cmd_e'(req_i.cmd);
    in_op.end_id     = req_i.end_id;
    in_op.status_in  = req_i.status_in;
    in_op.new_tag    = req_i.new_tag;
    in_op.now_ms     = req_i.now_ms;
    in_op.read_index = req_i.read_index;
  end

  assign req_i.ready = (cnt_q != QFULL);
  assign push        = req_i.valid && req_i.ready;
  assign op_valid_o  = (cnt_q != '0);
  assign pop         = op_pop_i && op_valid_o;
  assign op_o        = q_mem[rd_q];

  // Queue pointers and occupancy.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QLAST) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == QLAST) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= in_op;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/str_back.sv =====
`default_nettype none

module str_back #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         op_valid_i,
  input  wire str_pkg::op_t op_i,
  output logic              op_pop_o,
  str_rsp_if.source         rsp_o
);
  import str_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

  eng_state_e              state_q, state_d;
  op_t                     op_q, op_d;
  logic [PTR_W-1:0]        wp_q, wp_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic [ID_W-1:0]         id_q, id_d;
  logic [PTR_W-1:0]        cur_q, cur_d;
  logic [CNT_W-1:0]        idx_q, idx_d;

  rec_t                    mem [DEPTH];
  rec_t                    rd_q;
  logic                    mem_we;
  logic [PTR_W-1:0]        mem_waddr;
  rec_t                    mem_wdata;
  logic                    mem_re;
  logic [PTR_W-1:0]        mem_raddr;

  rsp_t                    rsp_q, res_d;
  logic                    rsp_valid_q;
  logic                    res_load;
  logic                    out_free;

  logic [PTR_W-1:0]        wp_prev, wp_next, cur_prev;
  logic [CNT_W+IDX_W-1:0]  fill_ext, ridx_ext;
  logic                    read_hit;
  logic [SUM_W-1:0]        wp_s, fill_s, base_s, sum_s, age_s;
  logic [PTR_W-1:0]        read_addr;

  // Ring pointer steps, wrapping at DEPTH.
  assign wp_prev  = (wp_q == '0) ? LAST_PTR : wp_q - PTR_W'(1);
  assign wp_next  = (wp_q == LAST_PTR) ? '0 : wp_q + PTR_W'(1);
  assign cur_prev = (cur_q == '0) ? LAST_PTR : cur_q - PTR_W'(1);

  // Map an age index to a slot: oldest entry sits fill slots behind the pointer.
  assign fill_ext  = {{IDX_W{1'b0}}, fill_q};
  assign ridx_ext  = {{CNT_W{1'b0}}, op_i.read_index};
  assign read_hit  = (ridx_ext < fill_ext);
  assign wp_s      = SUM_W'(wp_q);
  assign fill_s    = SUM_W'(fill_q);
  assign base_s    = (wp_s >= fill_s) ? wp_s - fill_s : wp_s + DEPTH_S - fill_s;
  assign sum_s     = base_s + SUM_W'(ridx_ext[CNT_W-1:0]);
  assign age_s     = (sum_s >= DEPTH_S) ? sum_s - DEPTH_S : sum_s;
  assign read_addr = age_s[PTR_W-1:0];

  assign out_free = !rsp_valid_q || rsp_o.ready;

  // Command sequencer.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    id_d      = id_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    mem_we    = 1'b0;
    mem_waddr = wp_q;
    mem_wdata = rd_q;
    mem_re    = 1'b0;
    mem_raddr = wp_prev;
    op_pop_o  = 1'b0;
    res_load  = 1'b0;
    res_d     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i && out_free) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          unique case (op_i.cmd)
            CMD_BEGIN: begin
              mem_we           = 1'b1;
              mem_waddr        = wp_q;
              mem_wdata        = '0;
              mem_wdata.id     = id_q;
              mem_wdata.tag    = op_i.new_tag;
              mem_wdata.start  = op_i.now_ms;
              mem_wdata.open   = 1'b1;
              wp_d             = wp_next;
              if (fill_q != FULL_CNT) begin
                fill_d = fill_q + CNT_W'(1);
              end
              id_d             = id_q + ID_W'(1);
              res_load         = 1'b1;
              res_d.span_id    = id_q;
            end
            CMD_END: begin
              if (fill_q == '0) begin
                res_load = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = wp_prev;
                cur_d     = wp_prev;
                idx_d     = '0;
                state_d   = ST_SEARCH;
              end
            end
            CMD_CLEAR: begin
              fill_d   = '0;
              wp_d     = '0;
              res_load = 1'b1;
            end
            CMD_READ: begin
              if (read_hit) begin
                mem_re    = 1'b1;
                mem_raddr = read_addr;
                state_d   = ST_READ;
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // rd_q holds the slot at cur_q; if the search goes on, the next older slot is fetched meanwhile.
        if (rd_q.open && (rd_q.id == op_q.end_id)) begin
          mem_we           = 1'b1;
          mem_waddr        = cur_q;
          mem_wdata        = rd_q;
          mem_wdata.open   = 1'b0;
          mem_wdata.stop   = op_q.now_ms;
          mem_wdata.status = op_q.status_in;
          res_load         = 1'b1;
          res_d.matched    = 1'b1;
          state_d          = ST_IDLE;
        end else if (idx_q == fill_q - CNT_W'(1)) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cur_prev;
          cur_d     = cur_prev;
          idx_d     = idx_q + CNT_W'(1);
        end
      end

      ST_READ: begin
        res_load          = 1'b1;
        res_d.span_id     = rd_q.id;
        res_d.entry_valid = 1'b1;
        res_d.entry_tag   = rd_q.tag;
        res_d.start_time  = rd_q.start;
        res_d.status_out  = rd_q.status;
        if (!rd_q.open) begin
          res_d.end_time = rd_q.stop;
          res_d.duration = rd_q.stop - rd_q.start;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.entry_count = CNT_OUT_W'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      id_q        <= ID_W'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      id_q    <= id_d;
      if (res_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    cur_q <= cur_d;
    idx_q <= idx_d;
    if (res_load) begin
      rsp_q <= res_d;
    end
  end

  // Span record memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.span_id     = rsp_q.span_id;
  assign rsp_o.matched     = rsp_q.matched;
  assign rsp_o.entry_count = rsp_q.entry_count;
  assign rsp_o.entry_valid = rsp_q.entry_valid;
  assign rsp_o.entry_tag   = rsp_q.entry_tag;
  assign rsp_o.start_time  = rsp_q.start_time;
  assign rsp_o.end_time    = rsp_q.end_time;
  assign rsp_o.duration    = rsp_q.duration;
  assign rsp_o.status_out  = rsp_q.status_out;

  // The ring never holds more than DEPTH spans.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count exceeds ring depth");

  // While a command is in flight the output register is empty.
  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !rsp_valid_q)
    else $error("result pending while engine busy");

  // The search never walks past the filled slots.
  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> idx_q < fill_q)
    else $error("search index beyond fill count");

  // Each begin takes exactly one id.
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o && (op_i.cmd == CMD_BEGIN) |=> id_q == $past(id_q) + ID_W'(1))
    else $error("id counter did not advance on begin");

endmodule

`default_nettype wire
